/* hw/rtl/utf8d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  localparam int MAX_SEQ_LEN = 6;
  localparam int CP_W        = 31;
  localparam int CNT_W       = 3;

  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = 3;
  localparam int Q_LVL_W = 4;

  localparam logic [7:0] BYTE_NUL     = 8'h00;
  localparam logic [1:0] CONT_PREFIX  = 2'b10;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;
    logic             end_of_text;
    logic             last;
  } result_t;

  // Up to two results written to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Keep the low 1+5*len bits of the accumulated value.
  function automatic logic [CP_W-1:0] mask_code(input logic [CP_W-1:0] acc,
                                                input logic [CNT_W-1:0] len);
    logic [5:0]      bits;
    logic [CP_W-1:0] mask;
    bits = 6'd1 + 6'd5 * {3'd0, len};
    mask = ~({CP_W{1'b1}} << bits);
    return acc & mask;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/utf8d_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module utf8d_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [7:0]                in_byte,
  input  wire logic [utf8d_pkg::Q_LVL_W-1:0] q_level,
  output logic                           in_ready,
  output utf8d_pkg::push_t               push
);
  import utf8d_pkg::*;

  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             pend_valid;
  logic [CP_W-1:0]  acc;
  logic [CNT_W-1:0] pend_len;

  logic    is_nul, is_ascii, is_cont, extend, flush, has_second;
  result_t pend_item, second_item;

  // Reserve room for the item still in the decode register.
  assign in_ready = ({1'b0, q_level} + {3'd0, stage_valid, 1'b0})
                    <= 5'(Q_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= in_valid && in_ready;
    end
    if (in_valid && in_ready) begin
      stage_byte <= in_byte;
    end
  end

  always_comb begin
    is_nul     = stage_byte == BYTE_NUL;
    is_ascii   = !stage_byte[7] && !is_nul;
    is_cont    = stage_byte[7:6] == CONT_PREFIX;
    extend     = is_cont && pend_valid && (pend_len < CNT_W'(MAX_SEQ_LEN));
    flush      = pend_valid && !extend;
    has_second = is_nul || is_ascii;

    pend_item.code_point  = mask_code(acc, pend_len);
    pend_item.byte_count  = pend_len;
    pend_item.end_of_text = 1'b0;
    pend_item.last        = !has_second;

    second_item.code_point  = is_nul ? '0 : {{(CP_W-8){1'b0}}, stage_byte};
    second_item.byte_count  = is_nul ? '0 : CNT_W'(1);
    second_item.end_of_text = is_nul;
    second_item.last        = 1'b1;

    push.count  = stage_valid ? ({1'b0, flush} + {1'b0, has_second}) : 2'd0;
    push.first  = flush ? pend_item : second_item;
    push.second = second_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      acc        <= '0;
      pend_len   <= '0;
    end else if (stage_valid) begin
      if (extend) begin
        acc      <= {acc[CP_W-7:0], stage_byte[5:0]};
        pend_len <= pend_len + CNT_W'(1);
      end else if (has_second) begin
        pend_valid <= 1'b0;
        acc        <= '0;
        pend_len   <= '0;
      end else begin
        pend_valid <= 1'b1;
        acc        <= {{(CP_W-8){1'b0}}, stage_byte};
        pend_len   <= CNT_W'(1);
      end
    end
  end

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    pend_len <= CNT_W'(MAX_SEQ_LEN))
    else $error("pending length beyond maximum");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend_len != '0)
    else $error("pending character with zero length");

  a_idle_no_push: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> push.count == 2'd0)
    else $error("results pushed without an item");

endmodule

`default_nettype wire

/* hw/rtl/utf8d_result_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module utf8d_result_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire utf8d_pkg::push_t           push,
  input  wire logic                       pop,
  output logic [utf8d_pkg::Q_LVL_W-1:0]   level,
  output utf8d_pkg::result_t              head
);
  import utf8d_pkg::*;

  result_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic               do_pop;

  assign do_pop = pop && (level != '0);
  assign head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + Q_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push.count);
      rd_ptr <= rd_ptr + Q_PTR_W'(do_pop);
      level  <= level + Q_LVL_W'(push.count) - Q_LVL_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, level} + {3'd0, push.count}) <= 5'(Q_DEPTH))
    else $error("result queue overflow");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= Q_LVL_W'(Q_DEPTH))
    else $error("result queue level out of range");

  a_level_track: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd0 && !do_pop) |=> $stable(level))
    else $error("queue level moved without push or pop");

endmodule

`default_nettype wire

/* hw/rtl/utf8_stream_decoder.sv */
// UTF-8 stream decoder (lenient, accepts five- and six-byte legacy forms).
// Input: s_tvalid/s_tready/s_tdata, one raw text byte per item; a zero byte
//   ends the text. One byte can be taken every cycle while s_tready is high.
// Output: m_tvalid/m_tready/m_tdata/m_tuser/m_tlast, one decoded character
//   per item. m_tuser flags the end-of-text item; m_tlast marks the final
//   result caused by an input byte.
// A multi-byte character is given when the byte after it arrives, since
// only then is it known to be complete. A byte can cause 0, 1 or 2 results.
// Path: a result passes the decode register, then the result queue, before
//   it shows on m_tvalid, which is driven from the registered queue level.
// Throughput: one byte per cycle while at most one result per byte is
//   produced and the queue has room; the output delivers one result per
//   cycle while m_tready is high, so bytes that cause two results are
//   limited by the output side. An 8-entry result queue absorbs bursts;
//   s_tready drops when the queue could not take two results for the byte
//   being decoded plus two for a new byte.
// Receiver stall: results wait in the queue, input keeps flowing until the
//   queue fills, then s_tready goes low. No result is dropped.
// Reset (rst, synchronous): nothing pending, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [30:0] code_point, [33:31] byte_count
  output logic             m_tuser,   // end_of_text
  output logic             m_tlast    // last
);
  import utf8d_pkg::*;

  push_t              push;
  result_t            head;
  logic [Q_LVL_W-1:0] level;

  utf8d_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .q_level  (level),
    .in_ready (s_tready),
    .push     (push)
  );

  utf8d_result_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (m_tready),
    .level (level),
    .head  (head)
  );

  assign m_tvalid = level != '0;
  assign m_tdata  = {6'd0, head.byte_count, head.code_point};
  assign m_tuser  = head.end_of_text;
  assign m_tlast  = head.last;

  a_eot_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[33:0] == '0 && m_tlast))
    else $error("end-of-text item with nonzero payload");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:31] <= 3'(MAX_SEQ_LEN))
    else $error("byte count beyond maximum");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> level <= Q_LVL_W'(Q_DEPTH - 2))
    else $error("input ready without queue room");

endmodule

`default_nettype wire

/* test/utf8_result_checker.sv */
`timescale 1ns / 1ps

module utf8_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,   // [30:0] code_point, [33:31] byte_count
  input  wire logic        m_tuser,   // end_of_text
  input  wire logic        m_tlast,   // last
  output int               fail_count,
  output int               outstanding
);
  import utf8d_pkg::*;

  result_t          char_q[$];
  logic             held;
  logic [CP_W-1:0]  acc;
  logic [CNT_W-1:0] held_len;

  function automatic logic [CP_W-1:0] keep_bits(input logic [CP_W-1:0] v,
                                                input logic [CNT_W-1:0] n);
    int bits;
    bits = 1 + 5 * n;
    if (bits >= CP_W) return v;
    return v & ((31'd1 << bits) - 31'd1);
  endfunction

  task automatic flush_held();
    result_t c;
    if (held) begin
      c = '0;
      c.code_point = keep_bits(acc, held_len);
      c.byte_count = held_len;
      char_q.push_back(c);
      held     = 1'b0;
      acc      = '0;
      held_len = '0;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    result_t c;
    int      n0;
    n0 = char_q.size();
    c  = '0;
    if (b == BYTE_NUL) begin
      flush_held();
      c.end_of_text = 1'b1;
      char_q.push_back(c);
    end else if (!b[7]) begin
      flush_held();
      c.code_point = {23'd0, b};
      c.byte_count = 3'd1;
      char_q.push_back(c);
    end else if (b[7:6] == CONT_PREFIX && held && held_len < MAX_SEQ_LEN) begin
      acc      = {acc[CP_W-7:0], b[5:0]};
      held_len = held_len + 3'd1;
    end else begin
      flush_held();
      held     = 1'b1;
      acc      = {23'd0, b};
      held_len = 3'd1;
    end
    if (char_q.size() > n0) begin
      c = char_q[char_q.size()-1];
      c.last = 1'b1;
      char_q[char_q.size()-1] = c;
    end
  endtask

  task automatic check_result();
    result_t w;
    logic    bad;
    if (char_q.size() == 0) begin
      fail_count++;
      $display("%0t: expected no item, got cp=%h cnt=%0d eot=%b last=%b", $time,
               m_tdata[30:0], m_tdata[33:31], m_tuser, m_tlast);
    end else begin
      w   = char_q.pop_front();
      bad = (m_tdata[30:0] !== w.code_point) || (m_tdata[33:31] !== w.byte_count) ||
            (m_tdata[39:34] !== 6'd0) || (m_tuser !== w.end_of_text) ||
            (m_tlast !== w.last);
      if (bad) begin
        fail_count++;
        $display("%0t: expected cp=%h cnt=%0d eot=%b last=%b pad=00", $time,
                 w.code_point, w.byte_count, w.end_of_text, w.last);
        $display("%0t: got      cp=%h cnt=%0d eot=%b last=%b pad=%h", $time,
                 m_tdata[30:0], m_tdata[33:31], m_tuser, m_tlast, m_tdata[39:34]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held       = 1'b0;
      acc        = '0;
      held_len   = '0;
      char_q.delete();
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata);
      if (m_tvalid && m_tready) check_result();
    end
    outstanding = char_q.size();
  end

endmodule

/* test/tb_utf8_stream_decoder.sv */
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import utf8d_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN    = 300;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int fail_count;
  int outstanding;
  int cycles     = 0;
  int src_idle   = 0;
  int sink_stall = 0;
  int bytes_sent = 0;
  bit hold_go    = 0;
  bit hold_done  = 0;
  int hold_left  = 0;

  utf8_stream_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  utf8_result_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      m_tready  <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] b[]);
    foreach (b[i]) send_byte(b[i]);
  endtask

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] free_mask;
    free_mask = (8'h01 << (7 - len)) - 8'h01;
    return (8'hFF << (8 - len)) | (8'($urandom) & free_mask);
  endfunction

  function automatic logic [7:0] cont_byte();
    return {CONT_PREFIX, 6'($urandom)};
  endfunction

  task automatic send_text(input int count);
    int stop;
    int kind;
    int len;
    int conts;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        send_byte(8'($urandom_range(8'h7F, 8'h01)));
      end else if (kind < 70) begin
        len = $urandom_range(MAX_SEQ_LEN, 2);
        send_byte(lead_byte(len));
        repeat (len - 1) send_byte(cont_byte());
      end else if (kind < 80) begin
        // truncated sequence
        len   = $urandom_range(MAX_SEQ_LEN, 2);
        conts = $urandom_range(len - 2, 0);
        send_byte(lead_byte(len));
        repeat (conts) send_byte(cont_byte());
      end else if (kind < 85) begin
        // run of continuations past the longest form
        send_byte(lead_byte($urandom_range(MAX_SEQ_LEN, 2)));
        conts = $urandom_range(MAX_SEQ_LEN + 3, MAX_SEQ_LEN);
        repeat (conts) send_byte(cont_byte());
      end else if (kind < 97) begin
        send_byte(8'($urandom));
      end else begin
        send_byte(BYTE_NUL);
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: NUL alone, ASCII extremes, stray continuation, 2/3/5/6-byte forms,
    // continuation after a full character, lead over lead, NUL flushing a pending one
    send_bytes('{8'h00, 8'h01, 8'h7F, 8'h80});
    send_bytes('{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC});
    send_bytes('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h80});
    send_bytes('{8'hFF, 8'hFE, 8'h41});
    send_bytes('{8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'hC3, 8'h00});

    // long receiver hold-off while the sender keeps offering
    hold_go = 1'b1;
    send_text(250);

    src_idle = 81;
    send_text(200);

    src_idle   = 0;
    sink_stall = 81;
    send_text(250);

    src_idle   = 24;
    sink_stall = 24;
    send_text(250);
    send_byte(BYTE_NUL);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
